>>> hw/rtl/rdz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdz_pkg: shared types and constants for the radial deadzone conditioner
// Payload structs, datapath widths, pipeline depths and register indexes.
// ----------------------------------------------------------------------------
package rdz_pkg;

	localparam int AXW  = 16;   // raw stick axis
	localparam int DZW  = 15;   // deadzone register
	localparam int TRW  = 8;    // trigger value
	localparam int RADW = 48;   // (x^2 + y^2) << 16
	localparam int MAGW = 24;   // magnitude, 8 fraction bits
	localparam int PAW  = 30;   // 32767 * |axis|
	localparam int NUMW = 54;   // divider numerator
	localparam int DENW = 39;   // divider denominator
	localparam int QW   = 16;   // quotient

	localparam int SQ_STAGES  = 6;
	localparam int SQ_STEPS   = 4;   // root bits per sqrt stage
	localparam int DIV_STAGES = 4;
	localparam int DIV_STEPS  = 4;   // quotient bits per divider stage

	localparam logic [DZW-1:0] AXIS_FULL = 15'd32767;
	localparam logic [TRW-1:0] TRIG_FULL = 8'd255;

	localparam logic [DZW-1:0] LEFT_DZ_RST  = 15'd7849;
	localparam logic [DZW-1:0] RIGHT_DZ_RST = 15'd8689;
	localparam logic [TRW-1:0] TRIG_THR_RST = 8'd30;

	typedef enum logic [1:0] {
		CFG_LEFT_DZ  = 2'd0,
		CFG_RIGHT_DZ = 2'd1,
		CFG_TRIG_THR = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [AXW-1:0] left_stick_x;
		logic signed [AXW-1:0] left_stick_y;
		logic signed [AXW-1:0] right_stick_x;
		logic signed [AXW-1:0] right_stick_y;
		logic        [TRW-1:0] left_trigger_raw;
		logic        [TRW-1:0] right_trigger_raw;
	} in_t;

	typedef struct packed {
		logic signed [AXW-1:0] left_out_x;
		logic signed [AXW-1:0] left_out_y;
		logic signed [AXW-1:0] right_out_x;
		logic signed [AXW-1:0] right_out_y;
		logic        [TRW-1:0] left_trigger_out;
		logic        [TRW-1:0] right_trigger_out;
	} out_t;

endpackage

>>> hw/rtl/gamepad_deadzone_conditioner.sv
`timescale 1ns / 1ps
// A sample passes stage 1, stage 2, the sqrt stages, stage 9, the divider stages and the output register.
// Throughput: one sample per cycle while the output is not stalled; 6 sqrt stages and 4 divider stages.
// A stalled output freezes the whole pipeline in place.
// Reset: arst_n clears valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// gamepad_deadzone_conditioner: scaled radial deadzone for sticks and triggers
// Magnitude by pipelined sqrt, axis and trigger rescale by pipelined division.
// ----------------------------------------------------------------------------
module gamepad_deadzone_conditioner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  rdz_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output rdz_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [rdz_pkg::DZW-1:0]       cfg_data
);
	import rdz_pkg::*;

	localparam int DEPTH = 3 + SQ_STAGES + 1 + DIV_STAGES;

	typedef struct packed {
		logic           neg_x;
		logic           neg_y;
		logic [AXW-1:0] ux;
		logic [AXW-1:0] uy;
	} stk_abs_t;

	typedef struct packed {
		logic           live;
		logic [QW-1:0]  num;
		logic [TRW-1:0] den;
	} trg_t;

	typedef struct packed {
		logic           lnx, lny, rnx, rny;
		logic [PAW-1:0] lpx, lpy, rpx, rpy;
		trg_t           lt, rt;
	} side_t;

	typedef struct packed {
		logic lnx, lny, rnx, rny;
		logic ldead, rdead;
		logic ltlive, rtlive;
	} post_t;

	// configuration
	logic [DZW-1:0] left_dz_q, right_dz_q;
	logic [TRW-1:0] trig_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dz_q  <= LEFT_DZ_RST;
			right_dz_q <= RIGHT_DZ_RST;
			trig_thr_q <= TRIG_THR_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LEFT_DZ:  left_dz_q  <= cfg_data;
				CFG_RIGHT_DZ: right_dz_q <= cfg_data;
				CFG_TRIG_THR: trig_thr_q <= cfg_data[TRW-1:0];
				default: ;
			endcase
		end
	end

	// valid bits and global advance
	logic [DEPTH-1:0] vld_q;
	logic             en;

	assign en        = !(vld_q[DEPTH-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	// stage 1: absolute values, trigger numerator and denominator
	function automatic stk_abs_t abs_stick(logic [AXW-1:0] x, logic [AXW-1:0] y);
		stk_abs_t s;
		s.neg_x = x[AXW-1];
		s.neg_y = y[AXW-1];
		s.ux    = x[AXW-1] ? (~x + 16'd1) : x;
		s.uy    = y[AXW-1] ? (~y + 16'd1) : y;
		return s;
	endfunction

	function automatic trg_t prep_trig(logic [TRW-1:0] v, logic [TRW-1:0] thr);
		trg_t           t;
		logic [TRW-1:0] d;
		d      = v - thr;
		t.live = v > thr;
		t.num  = {d, 8'b0} - {8'b0, d};
		t.den  = TRIG_FULL - thr;
		return t;
	endfunction

	stk_abs_t lstk_s1, rstk_s1;
	trg_t     ltrg_s1, rtrg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			lstk_s1 <= abs_stick(in_data.left_stick_x, in_data.left_stick_y);
			rstk_s1 <= abs_stick(in_data.right_stick_x, in_data.right_stick_y);
			ltrg_s1 <= prep_trig(in_data.left_trigger_raw, trig_thr_q);
			rtrg_s1 <= prep_trig(in_data.right_trigger_raw, trig_thr_q);
		end
	end

	// stage 2: radicand and 32767*|axis|
	function automatic logic [RADW-1:0] radicand(logic [AXW-1:0] ux, logic [AXW-1:0] uy);
		logic [2*AXW-1:0] sx, sy;
		sx = {{AXW{1'b0}}, ux} * {{AXW{1'b0}}, ux};
		sy = {{AXW{1'b0}}, uy} * {{AXW{1'b0}}, uy};
		return {sx + sy, 16'b0};
	endfunction

	// |axis| may be 32768, so the shift needs one bit above PAW
	function automatic logic [PAW-1:0] times_full(logic [AXW-1:0] u);
		logic [PAW:0] w;
		w = {u, 15'b0} - {{(PAW+1-AXW){1'b0}}, u};
		return w[PAW-1:0];
	endfunction

	logic [RADW-1:0] lrad_s2, rrad_s2;
	side_t           side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lrad_s2     <= radicand(lstk_s1.ux, lstk_s1.uy);
			rrad_s2     <= radicand(rstk_s1.ux, rstk_s1.uy);
			side_s2.lnx <= lstk_s1.neg_x;
			side_s2.lny <= lstk_s1.neg_y;
			side_s2.rnx <= rstk_s1.neg_x;
			side_s2.rny <= rstk_s1.neg_y;
			side_s2.lpx <= times_full(lstk_s1.ux);
			side_s2.lpy <= times_full(lstk_s1.uy);
			side_s2.rpx <= times_full(rstk_s1.ux);
			side_s2.rpy <= times_full(rstk_s1.uy);
			side_s2.lt  <= ltrg_s1;
			side_s2.rt  <= rtrg_s1;
		end
	end

	// stages 3..8: magnitude
	logic [MAGW-1:0] lmag, rmag;
	side_t           side_d [SQ_STAGES];

	rdz_sqrt u_sqrt_l (.clk(clk), .en(en), .rad(lrad_s2), .root(lmag));
	rdz_sqrt u_sqrt_r (.clk(clk), .en(en), .rad(rrad_s2), .root(rmag));

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQ_STAGES; k++) begin
				side_d[k] <= (k == 0) ? side_s2 : side_d[k-1];
			end
		end
	end

	// stage 9: deadzone test, numerators and denominators
	side_t           sd;
	logic [MAGW-1:0] lm, rm;
	logic            ldead, rdead;

	function automatic logic is_dead(logic [MAGW-1:0] mag, logic [DZW-1:0] dz);
		return ({1'b0, dz, 8'b0} >= mag) || (dz == AXIS_FULL);
	endfunction

	function automatic logic [MAGW-1:0] live_m(logic [MAGW-1:0] mag, logic [DZW-1:0] dz);
		logic [MAGW-1:0] cap;
		logic [MAGW-1:0] clip;
		cap  = {1'b0, AXIS_FULL, 8'b0};
		clip = (mag > cap) ? cap : mag;
		return clip - {1'b0, dz, 8'b0};
	endfunction

	assign sd    = side_d[SQ_STAGES-1];
	assign ldead = is_dead(lmag, left_dz_q);
	assign rdead = is_dead(rmag, right_dz_q);
	assign lm    = live_m(lmag, left_dz_q);
	assign rm    = live_m(rmag, right_dz_q);

	logic [NUMW-1:0] lnx_s9, lny_s9, rnx_s9, rny_s9, ltn_s9, rtn_s9;
	logic [DENW-1:0] lden_s9, rden_s9, ltd_s9, rtd_s9;
	post_t           post_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			lnx_s9  <= {{(NUMW-PAW){1'b0}}, sd.lpx} * {{(NUMW-MAGW){1'b0}}, lm};
			lny_s9  <= {{(NUMW-PAW){1'b0}}, sd.lpy} * {{(NUMW-MAGW){1'b0}}, lm};
			rnx_s9  <= {{(NUMW-PAW){1'b0}}, sd.rpx} * {{(NUMW-MAGW){1'b0}}, rm};
			rny_s9  <= {{(NUMW-PAW){1'b0}}, sd.rpy} * {{(NUMW-MAGW){1'b0}}, rm};
			lden_s9 <= {{(DENW-MAGW){1'b0}}, lmag}
				* {{(DENW-DZW){1'b0}}, (AXIS_FULL - left_dz_q)};
			rden_s9 <= {{(DENW-MAGW){1'b0}}, rmag}
				* {{(DENW-DZW){1'b0}}, (AXIS_FULL - right_dz_q)};
			ltn_s9  <= {{(NUMW-QW){1'b0}}, sd.lt.num};
			rtn_s9  <= {{(NUMW-QW){1'b0}}, sd.rt.num};
			ltd_s9  <= {{(DENW-TRW){1'b0}}, sd.lt.den};
			rtd_s9  <= {{(DENW-TRW){1'b0}}, sd.rt.den};
			post_s9 <= '{lnx: sd.lnx, lny: sd.lny, rnx: sd.rnx, rny: sd.rny,
			             ldead: ldead, rdead: rdead,
			             ltlive: sd.lt.live, rtlive: sd.rt.live};
		end
	end

	// stages 10..13: division
	logic [QW-1:0] qlx, qly, qrx, qry, qlt, qrt;
	post_t         post_d [DIV_STAGES];

	rdz_div u_div_lx (.clk(clk), .en(en), .num(lnx_s9), .den(lden_s9), .quo(qlx));
	rdz_div u_div_ly (.clk(clk), .en(en), .num(lny_s9), .den(lden_s9), .quo(qly));
	rdz_div u_div_rx (.clk(clk), .en(en), .num(rnx_s9), .den(rden_s9), .quo(qrx));
	rdz_div u_div_ry (.clk(clk), .en(en), .num(rny_s9), .den(rden_s9), .quo(qry));
	rdz_div u_div_lt (.clk(clk), .en(en), .num(ltn_s9), .den(ltd_s9),  .quo(qlt));
	rdz_div u_div_rt (.clk(clk), .en(en), .num(rtn_s9), .den(rtd_s9),  .quo(qrt));

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				post_d[k] <= (k == 0) ? post_s9 : post_d[k-1];
			end
		end
	end

	// stage 14: sign and zero forcing, output register
	function automatic logic [AXW-1:0] signed_axis(logic [QW-1:0] q, logic neg, logic dead);
		if (dead) begin
			return '0;
		end
		return neg ? (~q + 16'd1) : q;
	endfunction

	post_t pd;
	out_t  out_s14;

	assign pd = post_d[DIV_STAGES-1];

	always_ff @(posedge clk) begin
		if (en) begin
			out_s14.left_out_x        <= signed_axis(qlx, pd.lnx, pd.ldead);
			out_s14.left_out_y        <= signed_axis(qly, pd.lny, pd.ldead);
			out_s14.right_out_x       <= signed_axis(qrx, pd.rnx, pd.rdead);
			out_s14.right_out_y       <= signed_axis(qry, pd.rny, pd.rdead);
			out_s14.left_trigger_out  <= pd.ltlive ? qlt[TRW-1:0] : '0;
			out_s14.right_trigger_out <= pd.rtlive ? qrt[TRW-1:0] : '0;
		end
	end

	assign out_data = out_s14;

	// checks
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[0])
		else $error("accepted sample did not enter the pipeline");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

endmodule

>>> hw/rtl/rdz_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdz_sqrt: pipelined integer square root
// Restoring digit recurrence, SQ_STEPS root bits per stage, floor result.
// ----------------------------------------------------------------------------
module rdz_sqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [rdz_pkg::RADW-1:0]  rad,
	output logic [rdz_pkg::MAGW-1:0]  root
);
	import rdz_pkg::*;

	localparam int REMW = MAGW + 2;

	logic [RADW-1:0] rad_s  [SQ_STAGES];
	logic [REMW-1:0] rem_s  [SQ_STAGES];
	logic [MAGW-1:0] root_s [SQ_STAGES];
	logic [RADW-1:0] rad_n  [SQ_STAGES];
	logic [REMW-1:0] rem_n  [SQ_STAGES];
	logic [MAGW-1:0] root_n [SQ_STAGES];

	always_comb begin
		logic [RADW-1:0] r;
		logic [REMW-1:0] rm;
		logic [MAGW-1:0] rt;
		logic [REMW+1:0] rw;
		logic [REMW+1:0] t;
		for (int k = 0; k < SQ_STAGES; k++) begin
			if (k == 0) begin
				r  = rad;
				rm = '0;
				rt = '0;
			end else begin
				r  = rad_s[k-1];
				rm = rem_s[k-1];
				rt = root_s[k-1];
			end
			for (int j = 0; j < SQ_STEPS; j++) begin
				rw = {rm, r[RADW-1 -: 2]};
				t  = {2'b00, rt, 2'b01};
				if (rw >= t) begin
					rw = rw - t;
					rt = {rt[MAGW-2:0], 1'b1};
				end else begin
					rt = {rt[MAGW-2:0], 1'b0};
				end
				rm = rw[REMW-1:0];
				r  = {r[RADW-3:0], 2'b00};
			end
			rad_n[k]  = r;
			rem_n[k]  = rm;
			root_n[k] = rt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQ_STAGES; k++) begin
				rad_s[k]  <= rad_n[k];
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
			end
		end
	end

	assign root = root_s[SQ_STAGES-1];

endmodule

>>> hw/rtl/rdz_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdz_div: pipelined unsigned divider
// Restoring division, DIV_STEPS quotient bits per stage; quotient < 2^QW.
// ----------------------------------------------------------------------------
module rdz_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [rdz_pkg::NUMW-1:0]  num,
	input  logic [rdz_pkg::DENW-1:0]  den,
	output logic [rdz_pkg::QW-1:0]    quo
);
	import rdz_pkg::*;

	logic [NUMW-1:0] rem_s [DIV_STAGES];
	logic [DENW-1:0] den_s [DIV_STAGES];
	logic [QW-1:0]   q_s   [DIV_STAGES];
	logic [NUMW-1:0] rem_n [DIV_STAGES];
	logic [QW-1:0]   q_n   [DIV_STAGES];

	always_comb begin
		logic [NUMW-1:0] rm;
		logic [DENW-1:0] d;
		logic [QW-1:0]   q;
		logic [NUMW:0]   rw;
		logic [NUMW:0]   sh;
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				rm = num;
				d  = den;
				q  = '0;
			end else begin
				rm = rem_s[k-1];
				d  = den_s[k-1];
				q  = q_s[k-1];
			end
			for (int j = 0; j < DIV_STEPS; j++) begin
				rw = {1'b0, rm};
				sh = {{(NUMW+1-DENW){1'b0}}, d} << (QW - 1 - k * DIV_STEPS - j);
				if (rw >= sh) begin
					rw = rw - sh;
					q  = {q[QW-2:0], 1'b1};
				end else begin
					q  = {q[QW-2:0], 1'b0};
				end
				rm = rw[NUMW-1:0];
			end
			rem_n[k] = rm;
			q_n[k]   = q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				rem_s[k] <= rem_n[k];
				q_s[k]   <= q_n[k];
				den_s[k] <= (k == 0) ? den : den_s[k-1];
			end
		end
	end

	assign quo = q_s[DIV_STAGES-1];

endmodule
